// ===== src/chunk_reassembly_tracker_macros.svh =====
// Assertion macros used by the chunk reassembly tracker checker.
`ifndef CHUNK_REASSEMBLY_TRACKER_MACROS_SVH
`define CHUNK_REASSEMBLY_TRACKER_MACROS_SVH

// Checked only outside reset.
`define CRT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("crt assertion failed");

// Checked at every edge, reset included.
`define CRT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("crt assertion failed");

`endif

// ===== src/crt_pkg.sv =====
// Shared types and constants of the chunk reassembly tracker.
package crt_pkg;

    localparam int MAX_CHUNKS_DEF = 4096;
    localparam int MANIFEST_FIXED = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_IGNORE = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC    = 2'd0,
        REG_MANIFEST = 2'd1,
        REG_DATA     = 2'd2,
        REG_HEADER   = 2'd3
    } t_cfg_reg;

    localparam logic [31:0] MAGIC_RST  = 32'd0;
    localparam logic [7:0]  MCODE_RST  = 8'd0;
    localparam logic [7:0]  DCODE_RST  = 8'd1;
    localparam logic [7:0]  HEADER_RST = 8'd9;

endpackage

// ===== src/crt_if.sv =====
// Valid/ready channels carrying packet header words and result words.
interface crt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] magic_word;
    logic [7:0]  type_code;
    logic [11:0] packet_length;
    logic [15:0] chunk_index;
    logic [15:0] declared_total;
    logic [31:0] declared_crc;
    logic [31:0] declared_size;
    logic [15:0] declared_chunk;
    logic [7:0]  name_length;

    modport source (
        output valid, magic_word, type_code, packet_length, chunk_index,
               declared_total, declared_crc, declared_size, declared_chunk, name_length,
        input  ready
    );
    modport sink (
        input  valid, magic_word, type_code, packet_length, chunk_index,
               declared_total, declared_crc, declared_size, declared_chunk, name_length,
        output ready
    );
endinterface

interface crt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        write_valid;
    logic [31:0] write_offset;
    logic [11:0] write_length;
    logic        transfer_complete;
    logic [31:0] expected_checksum;

    modport source (
        output valid, status, write_valid, write_offset, write_length,
               transfer_complete, expected_checksum,
        input  ready
    );
    modport sink (
        input  valid, status, write_valid, write_offset, write_length,
               transfer_complete, expected_checksum,
        output ready
    );
endinterface

// ===== src/chunk_reassembly_tracker.sv =====
// Chunk reassembly tracker: header checks, manifest latch, chunk bitmap.
//
// i_in takes one parsed packet header word per handshake; o_out returns exactly
// one result word per input word, in order. i_cfg_we/i_cfg_idx/i_cfg_data write
// the magic word, manifest code, data code and header length; the user must
// write them only while idle, and the block itself does not enforce it.
//
// The input word is registered in the check stage, its result in the output
// register. No new word is taken until the check stage has finished the
// read-modify-write of the bitmap RAM (read on accept, written back in that stage).
//
// Reset: control state and configuration return to their defaults, then a sweep
// clears all MAX_CHUNKS bitmap entries, one entry per cycle; i_in.ready stays low
// during the sweep (configuration writes are still taken).
//
// Stall: a result waits in the output register while o_out.ready is low; one
// more input word is taken and then held in the check stage until the output
// register frees.
module chunk_reassembly_tracker #(
    parameter int MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    crt_in_if.sink                         i_in,
    crt_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [crt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [crt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  type_code;
        logic [11:0] packet_length;
        logic [15:0] chunk_index;
        logic [15:0] declared_total;
        logic [31:0] declared_crc;
        logic [31:0] declared_size;
        logic [15:0] declared_chunk;
        logic [7:0]  name_length;
    } t_item;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr;

    logic [31:0] r_magic;
    logic [7:0]  r_mcode;
    logic [7:0]  r_dcode;
    logic [7:0]  r_hb;

    logic        r_held, n_held;
    logic [31:0] r_checksum, n_checksum;
    logic [31:0] r_file_length, n_file_length;
    logic [15:0] r_chunk_bytes, n_chunk_bytes;
    logic [15:0] r_chunk_count, n_chunk_count;
    logic [15:0] r_rcount, n_rcount;

    t_item       r_it;
    logic [AW-1:0] r_slot;
    logic [31:0] r_off;

    logic              r_out_valid;
    crt_pkg::t_status  r_out_status, n_status;
    logic              r_out_wv, n_wv;
    logic [31:0]       r_out_off, n_off;
    logic [11:0]       r_out_len, n_len;
    logic              r_out_done;
    logic [31:0]       r_out_crc;

    logic        accept;
    logic        advance;
    logic [15:0] in_slot;
    logic [31:0] in_off;
    logic        map_bit;
    logic        set_bit;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic        ram_wdata;

    logic [11:0] hb12;
    logic [12:0] man_min;
    logic [12:0] man_full;
    logic [31:0] room;
    logic [11:0] payload;

    assign accept  = i_in.valid && i_in.ready;
    assign advance = !r_out_valid || o_out.ready;
    assign in_slot = i_in.chunk_index - 16'd1;
    assign in_off  = 32'(in_slot) * 32'(r_chunk_bytes);

    assign ram_we    = (r_state == S_CLEAR) || set_bit;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_slot;
    assign ram_wdata = (r_state != S_CLEAR);

    crt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CHUNKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_slot[AW-1:0]),
        .o_rdata (map_bit)
    );

    // Checks and state update of the word held in the check stage.
    always_comb begin
        n_state       = r_state;
        n_held        = r_held;
        n_checksum    = r_checksum;
        n_file_length = r_file_length;
        n_chunk_bytes = r_chunk_bytes;
        n_chunk_count = r_chunk_count;
        n_rcount      = r_rcount;
        n_status      = crt_pkg::ST_REJECT;
        n_wv          = 1'b0;
        n_off         = 32'd0;
        n_len         = 12'd0;
        set_bit       = 1'b0;

        hb12     = {4'd0, r_hb};
        man_min  = 13'(r_hb) + 13'(crt_pkg::MANIFEST_FIXED);
        man_full = man_min + 13'(r_it.name_length);
        room     = r_file_length - r_off;
        payload  = r_it.packet_length - hb12;

        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(MAX_CHUNKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (advance) begin
                    n_state = S_IDLE;
                    if (r_it.packet_length < hb12 || r_it.magic_word != r_magic) begin
                        n_status = crt_pkg::ST_REJECT;
                    end else if (r_it.type_code == r_mcode) begin
                        if ({1'b0, r_it.packet_length} < man_min) begin
                            n_status = crt_pkg::ST_REJECT;
                        end else if (r_held) begin
                            n_status = crt_pkg::ST_IGNORE;
                        end else if (r_it.declared_size == 32'd0
                                     || r_it.declared_chunk == 16'd0) begin
                            n_status = crt_pkg::ST_REJECT;
                        end else if ({1'b0, r_it.packet_length} < man_full) begin
                            n_status = crt_pkg::ST_REJECT;
                        end else if (r_it.declared_total == 16'd0
                                     || 17'(r_it.declared_total) > 17'(MAX_CHUNKS)) begin
                            n_status = crt_pkg::ST_REJECT;
                        end else begin
                            n_status      = crt_pkg::ST_ACCEPT;
                            n_held        = 1'b1;
                            n_checksum    = r_it.declared_crc;
                            n_file_length = r_it.declared_size;
                            n_chunk_bytes = r_it.declared_chunk;
                            n_chunk_count = r_it.declared_total;
                            n_rcount      = 16'd0;
                        end
                    end else if (r_it.type_code == r_dcode) begin
                        if (!r_held) begin
                            n_status = crt_pkg::ST_REJECT;
                        end else if (r_it.chunk_index == 16'd0
                                     || r_it.chunk_index > r_chunk_count) begin
                            n_status = crt_pkg::ST_REJECT;
                        end else if (map_bit) begin
                            n_status = crt_pkg::ST_IGNORE;
                        end else if (r_off >= r_file_length) begin
                            n_status = crt_pkg::ST_REJECT;
                        end else begin
                            n_status = crt_pkg::ST_ACCEPT;
                            n_wv     = 1'b1;
                            n_off    = r_off;
                            n_len    = (32'(payload) > room) ? room[11:0] : payload;
                            set_bit  = 1'b1;
                            n_rcount = r_rcount + 16'd1;
                        end
                    end else begin
                        n_status = crt_pkg::ST_REJECT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_magic       <= crt_pkg::MAGIC_RST;
            r_mcode       <= crt_pkg::MCODE_RST;
            r_dcode       <= crt_pkg::DCODE_RST;
            r_hb          <= crt_pkg::HEADER_RST;
            r_held        <= 1'b0;
            r_checksum    <= 32'd0;
            r_file_length <= 32'd0;
            r_chunk_bytes <= 16'd0;
            r_chunk_count <= 16'd0;
            r_rcount      <= 16'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_held        <= n_held;
            r_checksum    <= n_checksum;
            r_file_length <= n_file_length;
            r_chunk_bytes <= n_chunk_bytes;
            r_chunk_count <= n_chunk_count;
            r_rcount      <= n_rcount;

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end

            if (i_cfg_we) begin
                case (crt_pkg::t_cfg_reg'(i_cfg_idx))
                    crt_pkg::REG_MAGIC:    r_magic <= i_cfg_data;
                    crt_pkg::REG_MANIFEST: r_mcode <= i_cfg_data[7:0];
                    crt_pkg::REG_DATA:     r_dcode <= i_cfg_data[7:0];
                    crt_pkg::REG_HEADER:   r_hb    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (r_state == S_EXEC && advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // Payload registers, no reset.
        if (accept) begin
            r_it.magic_word     <= i_in.magic_word;
            r_it.type_code      <= i_in.type_code;
            r_it.packet_length  <= i_in.packet_length;
            r_it.chunk_index    <= i_in.chunk_index;
            r_it.declared_total <= i_in.declared_total;
            r_it.declared_crc   <= i_in.declared_crc;
            r_it.declared_size  <= i_in.declared_size;
            r_it.declared_chunk <= i_in.declared_chunk;
            r_it.name_length    <= i_in.name_length;
            r_slot              <= in_slot[AW-1:0];
            r_off               <= in_off;
        end

        if (r_state == S_EXEC && advance) begin
            r_out_status <= n_status;
            r_out_wv     <= n_wv;
            r_out_off    <= n_off;
            r_out_len    <= n_len;
            r_out_done   <= n_held && (n_rcount == n_chunk_count);
            r_out_crc    <= n_checksum;
        end
    end

    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_out_status;
    assign o_out.write_valid       = r_out_wv;
    assign o_out.write_offset      = r_out_off;
    assign o_out.write_length      = r_out_len;
    assign o_out.transfer_complete = r_out_done;
    assign o_out.expected_checksum = r_out_crc;
endmodule

// ===== src/crt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module crt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = crt_pkg::MAX_CHUNKS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/crt_checker.sv =====
// Port-level checker for the chunk reassembly tracker, bound to the top level.
`include "chunk_reassembly_tracker_macros.svh"

module crt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_status,
    input logic        i_out_write_valid,
    input logic [31:0] i_out_write_offset,
    input logic [11:0] i_out_write_length
);
    `CRT_ASSERT_ALWAYS(a_rst_no_out, i_clk, !i_rst_n |=> !i_out_valid)

    `CRT_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)

    `CRT_ASSERT(a_write_is_accept, i_clk, i_rst_n,
        i_out_valid && i_out_write_valid |-> i_out_status == crt_pkg::ST_ACCEPT)

    `CRT_ASSERT(a_no_write_zero, i_clk, i_rst_n,
        i_out_valid && !i_out_write_valid |->
            i_out_write_offset == 32'd0 && i_out_write_length == 12'd0)

    `CRT_ASSERT(a_stall_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status))
endmodule

bind chunk_reassembly_tracker crt_checker u_crt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_status       (o_out.status),
    .i_out_write_valid  (o_out.write_valid),
    .i_out_write_offset (o_out.write_offset),
    .i_out_write_length (o_out.write_length)
);
